// ===== rtl/tdpt_pkg.sv =====
package tdpt_pkg;

	localparam int WIDTH     = 32;
	localparam int DIV_WIDTH = (WIDTH + 1) / 2 + 1;
	localparam int CNT_WIDTH = $clog2(WIDTH);

	localparam logic [1:0] VERDICT_PRIME     = 2'd0;
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd1;
	localparam logic [1:0] VERDICT_NEITHER   = 2'd2;

	typedef struct packed {
		logic                     done;
		logic                     rem_zero;
		logic [WIDTH-1:0]         quotient;
	} div_res_t;

endpackage

// ===== rtl/tdpt_divider.sv =====
module tdpt_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [tdpt_pkg::WIDTH-1:0]         dividend,
	input  logic [tdpt_pkg::DIV_WIDTH-1:0]     divisor,
	output logic                               busy,
	output tdpt_pkg::div_res_t                 res
);

	logic                               busy_q;
	logic                               done_q;
	logic [tdpt_pkg::CNT_WIDTH-1:0]     cnt_q;
	logic [tdpt_pkg::WIDTH-1:0]         quo_q;
	logic [tdpt_pkg::DIV_WIDTH-1:0]     rem_q;
	logic [tdpt_pkg::DIV_WIDTH:0]       trial;
	logic [tdpt_pkg::DIV_WIDTH:0]       diff;
	logic                               fits;

	// One restoring step: bring down the next dividend bit and try the subtraction.
	assign trial = {rem_q, quo_q[tdpt_pkg::WIDTH-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = ~diff[tdpt_pkg::DIV_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= tdpt_pkg::CNT_WIDTH'(tdpt_pkg::WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[tdpt_pkg::WIDTH-2:0], fits};
			rem_q <= fits ? diff[tdpt_pkg::DIV_WIDTH-1:0] : trial[tdpt_pkg::DIV_WIDTH-1:0];
		end
	end

	assign busy         = busy_q;
	assign res.done     = done_q;
	assign res.rem_zero = (rem_q == '0);
	assign res.quotient = quo_q;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// An input below 2 gives its word in the cycle after acceptance.
// Otherwise each candidate divisor costs one full division on the shared divider,
// and candidates run from 2 up to the smallest factor or the square root of number.
// A new number is stalled until the word is taken; the restoring divider yields one quotient bit a cycle.
// Reset is asynchronous and active low; it returns the block to idle with no word pending.
module trial_division_prime_test (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         number_valid,
	output logic                         number_stall,
	input  logic [tdpt_pkg::WIDTH-1:0]   number,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [1:0]                   verdict,
	output logic [tdpt_pkg::WIDTH-1:0]   largest_factor
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_DIV  = 3'b010,
		S_OUT  = 3'b100
	} state_t;

	state_t                             state_q;
	logic                               start_q;
	logic [tdpt_pkg::WIDTH-1:0]         n_q;
	logic [tdpt_pkg::DIV_WIDTH-1:0]     d_q;
	logic [1:0]                         verdict_q;
	logic [tdpt_pkg::WIDTH-1:0]         factor_q;
	logic                               div_busy;
	tdpt_pkg::div_res_t                 div_res;
	logic                               past_root;

	tdpt_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (n_q),
		.divisor  (d_q),
		.busy     (div_busy),
		.res      (div_res)
	);

	assign past_root = div_res.quotient < tdpt_pkg::WIDTH'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (number_valid) begin
						if (number < tdpt_pkg::WIDTH'(2)) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_DIV;
							start_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						if (past_root || div_res.rem_zero) begin
							state_q <= S_OUT;
						end else begin
							start_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (!result_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				n_q       <= number;
				d_q       <= tdpt_pkg::DIV_WIDTH'(2);
				verdict_q <= tdpt_pkg::VERDICT_NEITHER;
				factor_q  <= '0;
			end
			S_DIV: begin
				if (div_res.done) begin
					if (past_root) begin
						verdict_q <= tdpt_pkg::VERDICT_PRIME;
						factor_q  <= '0;
					end else if (div_res.rem_zero) begin
						verdict_q <= tdpt_pkg::VERDICT_COMPOSITE;
						factor_q  <= div_res.quotient;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
			end
			S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign number_stall   = (state_q != S_IDLE);
	assign result_valid   = (state_q == S_OUT);
	assign verdict        = verdict_q;
	assign largest_factor = factor_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((verdict_q == tdpt_pkg::VERDICT_COMPOSITE) == (factor_q != '0)))
		else $error("Factor does not agree with the verdict.");

	assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !div_busy)
		else $error("Divider restarted while busy.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (d_q >= tdpt_pkg::DIV_WIDTH'(2)))
		else $error("Candidate divisor below two.");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == S_DIV))
		else $error("Divider finished outside the division state.");

endmodule
